// ----- rtl/core/vector3_normalize_defines.svh -----
// Assertion macros shared by the vector normalize RTL.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH

// Implication checked every clock edge outside reset.
`define V3N_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define V3N_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/v3n_pkg.sv -----
`default_nettype none
package v3n_pkg;

  localparam int unsigned CompW = 24;
  localparam int unsigned SqW   = 48;
  localparam int unsigned LenW  = 24;
  localparam int unsigned UnitW = 16;
  localparam int unsigned FracShift = 14;
  // divider: numerator |c|<<14 is 38 bits, quotient fits 15 bits (<= 16384)
  localparam int unsigned QuotW = 15;
  localparam int unsigned MagW  = 23;
  localparam int unsigned NumW  = MagW + 1 + FracShift;

  typedef struct packed {
    logic signed [CompW-1:0] vec_x;
    logic signed [CompW-1:0] vec_y;
    logic signed [CompW-1:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic        [SqW-1:0]   length_squared;
    logic        [LenW-1:0]  length;
    logic signed [UnitW-1:0] unit_x;
    logic signed [UnitW-1:0] unit_y;
    logic signed [UnitW-1:0] unit_z;
    logic                    zero_vector;
  } out_item_t;

  // Data handed from cell to cell along the chain.
  typedef struct packed {
    logic                vld;
    logic [SqW-1:0]      sq;
    logic [SqW-1:0]      rem;
    logic [LenW-1:0]     root;
    logic [MagW:0]       mag_x;
    logic [MagW:0]       mag_y;
    logic [MagW:0]       mag_z;
    logic                neg_x;
    logic                neg_y;
    logic                neg_z;
  } sqrt_bus_t;

  typedef struct packed {
    logic                vld;
    logic [SqW-1:0]      sq;
    logic [LenW-1:0]     len;
    logic [NumW-1:0]     rem_x;
    logic [NumW-1:0]     rem_y;
    logic [NumW-1:0]     rem_z;
    logic [QuotW-1:0]    q_x;
    logic [QuotW-1:0]    q_y;
    logic [QuotW-1:0]    q_z;
    logic                neg_x;
    logic                neg_y;
    logic                neg_z;
  } div_bus_t;

endpackage
`default_nettype wire

// ----- rtl/core/vector3_normalize.sv -----
`default_nettype none
// vector3_normalize: length and unit direction of a Q12.12 3-vector.
// Input channel in_valid_i/in_ready_o carries in_item_t (vec_x/y/z).
// Output channel out_valid_o/out_ready_i carries out_item_t: squared
// length Q24.24, floor length Q12.12, unit components Q2.14 truncated
// toward zero, and a zero_vector flag (unit fields forced to 0).
// Structure: one squaring stage, a chain of 24 root cells (one root bit
// each), a chain of 15 divide cells (one quotient bit per cell, all three
// components side by side), then an output register.
// Throughput: one transfer per cycle while the output is not stalled; every
// cell hands its data to the next cell each cycle that the chain advances.
// Stall: the whole chain advances only while the output register is empty
// or being taken, so in_ready_o = out_ready_i | ~out_valid_o; nothing is
// dropped and no item is repeated.
// Reset: valid bits of every cell and the output register clear; no
// clearing pass, the block accepts on the first cycle after reset.
`include "vector3_normalize_defines.svh"
module vector3_normalize import v3n_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);
  localparam int unsigned SqCells = LenW;
  localparam int unsigned DvCells = QuotW;

  logic      adv;
  sqrt_bus_t sq_bus_d, sq_bus_q;
  sqrt_bus_t sbus [SqCells+1];
  div_bus_t  dbus [DvCells+1];
  out_item_t out_d, out_q;
  logic      out_vld_q;

  // whole chain moves together
  assign adv        = out_ready_i | ~out_vld_q;
  assign in_ready_o = adv;

  // Stage 0: magnitudes and sum of squares (three 24x24 products).
  logic [MagW:0] ax, ay, az;
  always_comb begin
    ax = in_data_i.vec_x[CompW-1] ? 24'(-in_data_i.vec_x) : 24'(in_data_i.vec_x);
    ay = in_data_i.vec_y[CompW-1] ? 24'(-in_data_i.vec_y) : 24'(in_data_i.vec_y);
    az = in_data_i.vec_z[CompW-1] ? 24'(-in_data_i.vec_z) : 24'(in_data_i.vec_z);
    sq_bus_d       = '0;
    sq_bus_d.vld   = in_valid_i;
    sq_bus_d.sq    = 48'(ax) * 48'(ax) + 48'(ay) * 48'(ay) + 48'(az) * 48'(az);
    sq_bus_d.rem   = sq_bus_d.sq;
    sq_bus_d.mag_x = ax;
    sq_bus_d.mag_y = ay;
    sq_bus_d.mag_z = az;
    sq_bus_d.neg_x = in_data_i.vec_x[CompW-1];
    sq_bus_d.neg_y = in_data_i.vec_y[CompW-1];
    sq_bus_d.neg_z = in_data_i.vec_z[CompW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_bus_q <= '0;
    end else if (adv) begin
      sq_bus_q <= sq_bus_d;
    end
  end

  assign sbus[0] = sq_bus_q;

  // Root chain, most significant bit first.
  for (genvar g = 0; g < SqCells; g++) begin : g_sqrt
    v3n_sqrt_cell #(.Bit(SqCells - 1 - g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .bus_i (sbus[g]),
      .bus_o (sbus[g+1])
    );
  end

  // Hand-over: numerators |c| << 14.
  always_comb begin
    dbus[0]       = '0;
    dbus[0].vld   = sbus[SqCells].vld;
    dbus[0].sq    = sbus[SqCells].sq;
    dbus[0].len   = sbus[SqCells].root;
    dbus[0].rem_x = {sbus[SqCells].mag_x, {FracShift{1'b0}}};
    dbus[0].rem_y = {sbus[SqCells].mag_y, {FracShift{1'b0}}};
    dbus[0].rem_z = {sbus[SqCells].mag_z, {FracShift{1'b0}}};
    dbus[0].neg_x = sbus[SqCells].neg_x;
    dbus[0].neg_y = sbus[SqCells].neg_y;
    dbus[0].neg_z = sbus[SqCells].neg_z;
  end

  for (genvar g = 0; g < DvCells; g++) begin : g_div
    v3n_div_cell #(.Bit(DvCells - 1 - g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .bus_i (dbus[g]),
      .bus_o (dbus[g+1])
    );
  end

  // Sign restore and zero-vector handling.
  logic zv;
  always_comb begin
    zv                    = (dbus[DvCells].len == '0);
    out_d.length_squared  = dbus[DvCells].sq;
    out_d.length          = dbus[DvCells].len;
    out_d.zero_vector     = zv;
    out_d.unit_x = zv ? '0 : dbus[DvCells].neg_x ? -{1'b0, dbus[DvCells].q_x}
                                                 :  {1'b0, dbus[DvCells].q_x};
    out_d.unit_y = zv ? '0 : dbus[DvCells].neg_y ? -{1'b0, dbus[DvCells].q_y}
                                                 :  {1'b0, dbus[DvCells].q_y};
    out_d.unit_z = zv ? '0 : dbus[DvCells].neg_z ? -{1'b0, dbus[DvCells].q_z}
                                                 :  {1'b0, dbus[DvCells].q_z};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dbus[DvCells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `V3N_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_vld_q && !out_ready_i, out_vld_q && $stable(out_q), "output changed while stalled")
  `V3N_ASSERT_IMPL(a_ready_rule, clk_i, rst_ni, out_vld_q && !out_ready_i, !in_ready_o, "input taken while output stalled")
  `V3N_ASSERT_IMPL(a_zero_units, clk_i, rst_ni, out_vld_q && out_q.zero_vector, out_q.unit_x == '0 && out_q.unit_y == '0 && out_q.unit_z == '0 && out_q.length_squared == '0, "zero vector with nonzero fields")
  `V3N_ASSERT_IMPL(a_unit_range, clk_i, rst_ni, out_vld_q, out_q.unit_x <= 16'sd16384 && out_q.unit_x >= -16'sd16384, "unit_x out of range")
endmodule
`default_nettype wire

// ----- rtl/core/v3n_sqrt_cell.sv -----
`default_nettype none
// One restoring square-root digit: settles root bit Bit.
module v3n_sqrt_cell import v3n_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire sqrt_bus_t bus_i,
  output sqrt_bus_t      bus_o
);
  // trial = (root << (Bit+1)) + (1 << 2*Bit), root holds bits above Bit
  logic [SqW+1:0] trial;
  sqrt_bus_t      bus_d, bus_q;

  always_comb begin
    trial = ({26'd0, bus_i.root} << (Bit + 1)) + ({{(SqW+1){1'b0}}, 1'b1} << (2 * Bit));
    bus_d = bus_i;
    if ({2'b00, bus_i.rem} >= trial) begin
      bus_d.rem       = bus_i.rem - trial[SqW-1:0];
      bus_d.root[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= '0;
    end else if (en_i) begin
      bus_q <= bus_d;
    end
  end

  assign bus_o = bus_q;
endmodule
`default_nettype wire

// ----- rtl/core/v3n_div_cell.sv -----
`default_nettype none
// One restoring divide step on all three components: quotient bit Bit.
module v3n_div_cell import v3n_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire div_bus_t bus_i,
  output div_bus_t      bus_o
);
  logic [NumW+QuotW-1:0] dsh;
  div_bus_t              bus_d, bus_q;

  always_comb begin
    dsh   = {{(NumW+QuotW-LenW){1'b0}}, bus_i.len} << Bit;
    bus_d = bus_i;
    if ({{QuotW{1'b0}}, bus_i.rem_x} >= dsh) begin
      bus_d.rem_x    = bus_i.rem_x - dsh[NumW-1:0];
      bus_d.q_x[Bit] = 1'b1;
    end
    if ({{QuotW{1'b0}}, bus_i.rem_y} >= dsh) begin
      bus_d.rem_y    = bus_i.rem_y - dsh[NumW-1:0];
      bus_d.q_y[Bit] = 1'b1;
    end
    if ({{QuotW{1'b0}}, bus_i.rem_z} >= dsh) begin
      bus_d.rem_z    = bus_i.rem_z - dsh[NumW-1:0];
      bus_d.q_z[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= '0;
    end else if (en_i) begin
      bus_q <= bus_d;
    end
  end

  assign bus_o = bus_q;
endmodule
`default_nettype wire
